>>> rtl/sfcd_pkg.sv
// Shared constants, types and status codes of the SBUS frame channel decoder.
`timescale 1ns / 1ps
`default_nettype none

package sfcd_pkg;

  // Frame geometry.
  localparam int FRAME_LEN     = 25;
  localparam int STORE_DEPTH   = FRAME_LEN - 1;
  localparam int FLAG_BYTE     = 23;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 5;

  // Channel layout.
  localparam int NUM_CHANNELS  = 10;
  localparam int CHAN_W        = 11;
  localparam int STATUS_W      = 3;
  localparam int PAYLOAD_BYTES = (NUM_CHANNELS * CHAN_W + BYTE_W - 1) / BYTE_W;
  localparam int PAYLOAD_FIRST = 1;

  // Failsafe and frame-lost bits of the flag byte.
  localparam int FAILSAFE_BIT  = 3;
  localparam int LOST_BIT      = 2;

  // Stream and configuration widths.
  localparam int IN_DATA_W     = 8;
  localparam int OUT_BITS      = STATUS_W + NUM_CHANNELS * CHAN_W;
  localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HEADER = 1'b0,
    REG_FOOTER = 1'b1
  } sfcd_reg_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_FOOTER = 3'd2,
    ST_FAILSAFE   = 3'd3,
    ST_FRAME_LOST = 3'd4
  } sfcd_status_t;

  // One decoded frame.
  typedef struct packed {
    sfcd_status_t                         status;
    logic [NUM_CHANNELS-1:0][CHAN_W-1:0]  chan;
  } sfcd_result_t;

  // Expected framing bytes.
  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] footer;
  } sfcd_cfg_t;

endpackage

`default_nettype wire

>>> rtl/sbus_frame_channel_decoder_core.sv
// Top level of the SBUS frame channel decoder: byte chain, counter and result register.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one serial byte per clock cycle and collects a 25-byte
// frame in a chain of 24 byte cells that shifts once for every stored byte.
// A word with in_tuser set always starts a new frame; bytes outside a frame
// are dropped. When the 25th byte arrives, the header, footer and flag
// checks and the unpacking of the ten 11-bit channels are done in that same
// cycle and the result is loaded into the output register, so it appears on
// out_tdata in the cycle after the last byte. Every cycle can take a byte; the
// input stalls only while a finished result sits in the output register and
// out_tready is low. Header and footer values are written through the cfg port;
// the user must write them only while the block is idle; the block does not enforce it.
module sbus_frame_channel_decoder_core
  import sfcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input byte stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]            in_tuser,   // [0] frame_begin
  // Decoded frame stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [2:0] status, then chan0..chan9,
                                                 // 11 bits each, zero padded
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STORE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_IDLE = CNT_W'(FRAME_LEN);

  sfcd_cfg_t                        cfg_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [CNT_W-1:0]                 cnt_nxt;
  logic [CNT_W-1:0]                 cnt_eff;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  sfcd_result_t                     res_r;
  sfcd_result_t                     res_calc;
  logic                             in_fire;
  logic                             shift_en;
  logic                             frame_done;
  logic [BYTE_W-1:0]                cell_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0][BYTE_W-1:0] frame_bytes;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header <= 8'd15;
      cfg_r.footer <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HEADER: cfg_r.header <= cfg_wdata;
        REG_FOOTER: cfg_r.footer <= cfg_wdata;
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  // Handshake: a byte is taken unless a result is stuck in the output register.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Byte position of the incoming word, restarted by a frame begin.
  assign cnt_eff    = in_tuser[0] ? '0 : cnt_r;
  assign shift_en   = in_fire && (cnt_eff < CNT_LAST);
  assign frame_done = in_fire && (cnt_eff == CNT_LAST);

  always_comb begin
    cnt_nxt = cnt_r;
    if (shift_en) begin
      cnt_nxt = cnt_eff + CNT_W'(1);
    end else if (frame_done) begin
      cnt_nxt = CNT_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_IDLE;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Chain of byte cells; cell 0 takes the new byte, the oldest byte sits at the far end.
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      sfcd_byte_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (in_tdata[BYTE_W-1:0]),
        .q_out    (cell_q[i])
      );
    end else begin : g_body
      sfcd_byte_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell_q[i-1]),
        .q_out    (cell_q[i])
      );
    end
    assign frame_bytes[STORE_DEPTH-1-i] = cell_q[i];
  end

  sfcd_frame_check u_check (
    .frame       (frame_bytes),
    .footer_byte (in_tdata[BYTE_W-1:0]),
    .cfg         (cfg_r),
    .result      (res_calc)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (frame_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      res_r <= res_calc;
    end
  end

  // Pack the result word.
  always_comb begin
    out_tdata = '0;
    out_tdata[STATUS_W-1:0] = res_r.status;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      out_tdata[STATUS_W + k*CHAN_W +: CHAN_W] = res_r.chan[k];
    end
  end

  assign out_tvalid = out_valid_r;

  // A new result appears only right after the last byte of a frame.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && !in_tuser[0] && cnt_r == CNT_LAST))
    else $error("result appeared without a completed frame");

  // The byte counter never leaves its legal range.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_IDLE)
    else $error("byte counter out of range");

  // A frame begin always leaves one stored byte behind.
  a_begin_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser[0]) |=> cnt_r == CNT_W'(1))
    else $error("frame begin did not restart capture");

  // A completed frame returns the decoder to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> (cnt_r == CNT_IDLE) && out_valid_r)
    else $error("frame completion did not load result and go idle");

endmodule

`default_nettype wire

>>> rtl/sfcd_byte_cell.sv
// One byte cell of the frame shift chain.
`timescale 1ns / 1ps
`default_nettype none

module sfcd_byte_cell
  import sfcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              shift_en,
  input  wire logic [BYTE_W-1:0] d_in,
  output logic      [BYTE_W-1:0] q_out
);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  // Take the neighbor's byte when the chain advances.
  always_comb begin
    byte_nxt = shift_en ? d_in : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q_out = byte_r;

endmodule

`default_nettype wire

>>> rtl/sfcd_frame_check.sv
// Framing checks and channel unpacking of a complete frame.
`timescale 1ns / 1ps
`default_nettype none

module sfcd_frame_check
  import sfcd_pkg::*;
(
  input  wire logic [STORE_DEPTH-1:0][BYTE_W-1:0] frame,
  input  wire logic [BYTE_W-1:0]                  footer_byte,
  input  wire sfcd_cfg_t                          cfg,
  output sfcd_result_t                            result
);

  logic [PAYLOAD_BYTES*BYTE_W-1:0] payload;
  logic                            header_ok;
  logic                            footer_ok;

  // Payload bits start at bit 0 of frame byte 1.
  always_comb begin
    for (int j = 0; j < PAYLOAD_BYTES; j++) begin
      payload[j*BYTE_W +: BYTE_W] = frame[PAYLOAD_FIRST + j];
    end
  end

  assign header_ok = (frame[0] == cfg.header);
  assign footer_ok = (footer_byte == cfg.footer);

  // Status in priority order; channels are zeroed on bad framing.
  always_comb begin
    if (!header_ok) begin
      result.status = ST_BAD_HEADER;
    end else if (!footer_ok) begin
      result.status = ST_BAD_FOOTER;
    end else if (frame[FLAG_BYTE][FAILSAFE_BIT]) begin
      result.status = ST_FAILSAFE;
    end else if (frame[FLAG_BYTE][LOST_BIT]) begin
      result.status = ST_FRAME_LOST;
    end else begin
      result.status = ST_OK;
    end
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      result.chan[k] = (header_ok && footer_ok) ? payload[k*CHAN_W +: CHAN_W] : '0;
    end
  end

endmodule

`default_nettype wire
